// ----- sv/irpwc_pkg.sv -----
// shared types and constants for the ir pulse width capture block
// no dependencies; imported by every module of the block
`default_nettype none
package irpwc_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_GLITCH      = 3'd0;
    localparam logic [2:0] CFG_END_GAP     = 3'd1;
    localparam logic [2:0] CFG_IDLE_PERIOD = 3'd2;
    localparam logic [2:0] CFG_IDLE_LIMIT  = 3'd3;
    localparam logic [2:0] CFG_LEN_LIMIT   = 3'd4;

    // register reset values
    localparam logic [7:0]  RST_GLITCH      = 8'd5;
    localparam logic [15:0] RST_END_GAP     = 16'd6000;
    localparam logic [15:0] RST_IDLE_PERIOD = 16'd50000;
    localparam logic [7:0]  RST_IDLE_LIMIT  = 8'd30;
    localparam logic [9:0]  RST_LEN_LIMIT   = 10'd756;

    // result kinds
    localparam logic [1:0] KIND_DATA     = 2'd0;
    localparam logic [1:0] KIND_COMPLETE = 2'd1;
    localparam logic [1:0] KIND_TIMEOUT  = 2'd2;
    localparam logic [1:0] KIND_OVERFLOW = 2'd3;

    // job codes handed from the classifier to the emitter
    localparam logic [1:0] OP_DURATION = 2'd0;
    localparam logic [1:0] OP_COMPLETE = 2'd1;
    localparam logic [1:0] OP_TIMEOUT  = 2'd2;
    localparam logic [1:0] OP_OVERFLOW = 2'd3;

    localparam logic [9:0] INDEX_MAX = 10'd1023;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef struct packed {
        logic [7:0]  glitch_ticks;
        logic [15:0] end_gap_ticks;
        logic [15:0] idle_period_ticks;
        logic [7:0]  idle_periods_limit;
        logic [9:0]  length_limit;
    } t_cfg;

    // duration jobs carry the saturated duration, completion carries the total length
    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] value;
    } t_job;

endpackage
`default_nettype wire

// ----- sv/irpwc_front.sv -----
// classifier: per-sample mark/space/idle state machine, issues one job per event
// depends on irpwc_pkg
`default_nettype none
module irpwc_front #(
    parameter int HEADER_BYTES = 5,
    parameter int COUNT_WIDTH  = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  irpwc_pkg::t_cfg      i_cfg,
    input  wire                  i_valid,
    input  wire                  i_command,
    input  wire                  i_level,
    output logic                 o_ready,
    input  wire                  i_full,
    output logic                 o_push,
    output irpwc_pkg::t_job      o_job
);
    import irpwc_pkg::*;

    localparam logic [1:0] PH_OFF   = 2'd0;
    localparam logic [1:0] PH_MARK  = 2'd1;
    localparam logic [1:0] PH_SPACE = 2'd2;
    localparam logic [1:0] PH_IDLE  = 2'd3;

    localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);
    localparam logic [9:0] HEADER = 10'(HEADER_BYTES);

    function automatic logic [9:0] sat_add(input logic [9:0] a, input logic [2:0] b);
        logic [10:0] s;
        s = {1'b0, a} + {8'd0, b};
        sat_add = (s > {1'b0, INDEX_MAX}) ? INDEX_MAX : s[9:0];
    endfunction

    logic [1:0]             r_phase, n_phase;
    logic [COUNT_WIDTH-1:0] r_tick, n_tick;
    logic [9:0]             r_windex, n_windex;
    logic [7:0]             r_idle, n_idle;

    logic                   w_accept;
    logic [COUNT_WIDTH-1:0] w_tick_inc;
    logic [CMP_W-1:0]       w_tick_ext, w_inc_ext;
    logic [15:0]            w_dur;
    logic [2:0]             w_dur_bytes;
    logic                   w_full_len;
    logic [8:0]             w_idle_next;

    assign o_ready  = !i_full;
    assign w_accept = i_valid && o_ready;

    assign w_tick_inc  = (r_tick == COUNT_MAX) ? r_tick : r_tick + COUNT_ONE;
    assign w_tick_ext  = CMP_W'(r_tick);
    assign w_inc_ext   = CMP_W'(w_tick_inc);
    assign w_dur       = (w_tick_ext > CMP_W'(16'hFFFF)) ? 16'hFFFF : w_tick_ext[15:0];
    // a duration with zero low byte is sent as its high byte alone
    assign w_dur_bytes = (w_dur[7:0] != 8'd0) ? 3'd4 : 3'd1;
    assign w_full_len  = (r_windex >= i_cfg.length_limit);
    assign w_idle_next = {1'b0, r_idle} + 9'd1;

    always_comb begin
        n_phase  = r_phase;
        n_tick   = r_tick;
        n_windex = r_windex;
        n_idle   = r_idle;
        o_push   = 1'b0;
        o_job    = '{op: OP_DURATION, value: w_dur};
        if (w_accept) begin
            if (i_command) begin
                n_phase  = PH_MARK;
                n_tick   = COUNT_ONE;
                n_windex = HEADER;
                n_idle   = 8'd0;
            end else begin
                case (r_phase)
                    PH_MARK: begin
                        if (w_full_len) begin
                            o_push    = 1'b1;
                            o_job.op  = OP_OVERFLOW;
                            o_job.value = 16'd0;
                            n_phase   = PH_OFF;
                        end else if (!i_level) begin
                            n_tick = w_tick_inc;
                        end else if (w_tick_ext > CMP_W'(i_cfg.glitch_ticks)) begin
                            o_push   = 1'b1;
                            n_windex = sat_add(r_windex, w_dur_bytes);
                            n_tick   = COUNT_ONE;
                            n_phase  = PH_SPACE;
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_SPACE: begin
                        if (i_level) begin
                            n_tick = w_tick_inc;
                            if (w_inc_ext > CMP_W'(i_cfg.end_gap_ticks)) begin
                                n_windex    = sat_add(r_windex, 3'd1);
                                o_push      = 1'b1;
                                o_job.op    = OP_COMPLETE;
                                o_job.value = {6'd0, n_windex};
                                n_phase     = PH_OFF;
                            end
                        end else if (w_full_len) begin
                            o_push      = 1'b1;
                            o_job.op    = OP_OVERFLOW;
                            o_job.value = 16'd0;
                            n_phase     = PH_OFF;
                        end else begin
                            o_push   = 1'b1;
                            n_windex = sat_add(r_windex, w_dur_bytes);
                            n_idle   = 8'd0;
                            n_tick   = COUNT_ONE;
                            n_phase  = PH_MARK;
                        end
                    end
                    PH_IDLE: begin
                        if (i_level) begin
                            n_tick = w_tick_inc;
                            if (w_inc_ext > CMP_W'(i_cfg.idle_period_ticks)) begin
                                n_tick = '0;
                                if (w_idle_next > {1'b0, i_cfg.idle_periods_limit}) begin
                                    o_push      = 1'b1;
                                    o_job.op    = OP_TIMEOUT;
                                    o_job.value = 16'd0;
                                    n_phase     = PH_OFF;
                                end else begin
                                    n_idle = w_idle_next[7:0];
                                end
                            end
                        end else begin
                            n_tick  = COUNT_ONE;
                            n_phase = PH_MARK;
                        end
                    end
                    default: begin
                        // disarmed: samples are dropped
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_OFF;
            r_tick   <= '0;
            r_windex <= HEADER;
            r_idle   <= 8'd0;
        end else begin
            r_phase  <= n_phase;
            r_tick   <= n_tick;
            r_windex <= n_windex;
            r_idle   <= n_idle;
        end
    end

    a_windex_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_windex >= HEADER)
        else $error("write index below header length");
    a_push_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> w_accept && !i_command)
        else $error("job issued without a sample transfer");
    a_off_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_OFF) |-> !o_push)
        else $error("job issued while disarmed");

endmodule
`default_nettype wire

// ----- sv/irpwc_queue.sv -----
// short job queue between the classifier and the emitter
// depends on irpwc_pkg
`default_nettype none
module irpwc_queue (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  irpwc_pkg::t_job      i_job,
    output logic                 o_full,
    output logic                 o_head_valid,
    output irpwc_pkg::t_job      o_head,
    input  wire                  i_pop
);
    import irpwc_pkg::*;

    t_job                r_slot [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wptr, r_rptr;
    logic [QUEUE_AW:0]   r_count;
    logic                w_push, w_pop;

    assign o_full       = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_slot[r_rptr];
    assign w_push       = i_push && !o_full;
    assign w_pop        = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QUEUE_AW+1)'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count missed a push");
    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_push) |=> r_count == $past(r_count) - 1'b1)
        else $error("queue count missed a pop");

endmodule
`default_nettype wire

// ----- sv/irpwc_back.sv -----
// emitter: expands each queued job into one to four result transfers
// depends on irpwc_pkg; output register decouples the downstream stall
`default_nettype none
module irpwc_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_head_valid,
    input  irpwc_pkg::t_job      i_head,
    output logic                 o_pop,
    output logic                 o_valid,
    input  wire                  i_ready,
    output logic [1:0]           o_kind,
    output logic [7:0]           o_byte,
    output logic [9:0]           o_total,
    output logic                 o_last
);
    import irpwc_pkg::*;

    logic [1:0] r_beat;
    logic       r_valid;
    logic [1:0] r_kind;
    logic [7:0] r_byte;
    logic [9:0] r_total;
    logic       r_last;

    logic       w_load;
    logic [1:0] w_kind;
    logic [7:0] w_byte;
    logic [9:0] w_total;
    logic       w_last;

    // current beat of the job at the queue head
    always_comb begin
        w_kind  = KIND_DATA;
        w_byte  = 8'd0;
        w_total = 10'd0;
        w_last  = 1'b1;
        case (i_head.op)
            OP_DURATION: begin
                if (i_head.value[7:0] == 8'd0) begin
                    w_byte = i_head.value[15:8];
                end else begin
                    case (r_beat)
                        2'd2:    w_byte = i_head.value[7:0];
                        2'd3:    w_byte = i_head.value[15:8];
                        default: w_byte = 8'd0;
                    endcase
                    w_last = (r_beat == 2'd3);
                end
            end
            OP_COMPLETE: begin
                // zero terminator byte, then the completion with total length
                if (r_beat == 2'd0) begin
                    w_last = 1'b0;
                end else begin
                    w_kind  = KIND_COMPLETE;
                    w_total = i_head.value[9:0];
                end
            end
            OP_TIMEOUT: w_kind = KIND_TIMEOUT;
            OP_OVERFLOW: w_kind = KIND_OVERFLOW;
            default: w_kind = KIND_DATA;
        endcase
    end

    assign w_load = i_head_valid && (!r_valid || i_ready);
    assign o_pop  = w_load && w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_beat  <= 2'd0;
        end else if (w_load) begin
            r_valid <= 1'b1;
            r_beat  <= w_last ? 2'd0 : r_beat + 2'd1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_kind  <= w_kind;
            r_byte  <= w_byte;
            r_total <= w_total;
            r_last  <= w_last;
        end
    end

    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_byte  = r_byte;
    assign o_total = r_total;
    assign o_last  = r_last;

    a_beat_has_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_beat != 2'd0) |-> i_head_valid)
        else $error("job left the queue in mid expansion");
    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_head_valid && (i_head.op == OP_TIMEOUT || i_head.op == OP_OVERFLOW))
            |-> r_beat == 2'd0)
        else $error("single result job in mid expansion");
    a_complete_beats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_head_valid && i_head.op == OP_COMPLETE) |-> r_beat <= 2'd1)
        else $error("completion job beyond two results");

endmodule
`default_nettype wire

// ----- sv/ir_pulse_width_capture.sv -----
// top level of the ir pulse width capture block
// instantiates irpwc_front, irpwc_queue and irpwc_back; depends on irpwc_pkg
//
// usage
//   sample channel (s): one transfer per timer tick. tuser is the command
//   (0 sample, 1 arm a new capture), tdata[0] the receiver level, low while
//   carrier is present. a capture measures marks and spaces in ticks, drops
//   short marks, counts idle periods and ends on a long space, an idle
//   timeout or the length limit.
//   result channel (m): tdata[7:0] encoded duration byte, tdata[17:8] total
//   length on completion; tuser is the result kind; tlast marks the final
//   result caused by one sample.
//   config channel: index 0..4 selects glitch, end gap, idle period, idle
//   limit and length limit; other indexes are ignored. always ready.
// timing
//   a sample is taken every cycle while the job queue has room. the first result of a
//   sample passes through the job queue and the output register. the result side moves
//   one result per cycle while tready is high, so a four byte duration holds the emitter
//   for four results; the four entry job queue absorbs bursts before tready drops.
// reset
//   synchronous, active low: disarmed, registers at their defaults, queue
//   and output register empty. a stalled result holds until taken.
`default_nettype none
module ir_pulse_width_capture #(
    parameter int HEADER_BYTES = 5,
    parameter int COUNT_WIDTH  = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // sample input
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [7:0]  i_s_tdata,   // [0] ir_level, [7:1] zero
    input  wire         i_s_tuser,   // [0] command
    // result output
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [23:0] o_m_tdata,   // [7:0] data_byte, [17:8] total_length, [23:18] zero
    output logic [1:0]  o_m_tuser,   // [1:0] kind
    output logic        o_m_tlast,
    // configuration write
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [15:0] i_cfg_data
);
    import irpwc_pkg::*;

    t_cfg       r_cfg;
    t_job       w_push_job, w_head;
    logic       w_push, w_full, w_head_valid, w_pop;
    logic [7:0] w_byte;
    logic [9:0] w_total;

    // configuration registers, to be written only while idle; the block does not enforce it
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.glitch_ticks       <= RST_GLITCH;
            r_cfg.end_gap_ticks      <= RST_END_GAP;
            r_cfg.idle_period_ticks  <= RST_IDLE_PERIOD;
            r_cfg.idle_periods_limit <= RST_IDLE_LIMIT;
            r_cfg.length_limit       <= RST_LEN_LIMIT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_GLITCH:      r_cfg.glitch_ticks       <= i_cfg_data[7:0];
                CFG_END_GAP:     r_cfg.end_gap_ticks      <= i_cfg_data;
                CFG_IDLE_PERIOD: r_cfg.idle_period_ticks  <= i_cfg_data;
                CFG_IDLE_LIMIT:  r_cfg.idle_periods_limit <= i_cfg_data[7:0];
                CFG_LEN_LIMIT:   r_cfg.length_limit       <= i_cfg_data[9:0];
                default: begin
                    // unknown index: dropped
                end
            endcase
        end
    end

    // classifier: tracks the capture and turns events into jobs
    irpwc_front #(
        .HEADER_BYTES (HEADER_BYTES),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (i_s_tvalid),
        .i_command (i_s_tuser),
        .i_level   (i_s_tdata[0]),
        .o_ready   (o_s_tready),
        .i_full    (w_full),
        .o_push    (w_push),
        .o_job     (w_push_job)
    );

    // job queue lets the sample side run while long encodings drain
    irpwc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_job        (w_push_job),
        .o_full       (w_full),
        .o_head_valid (w_head_valid),
        .o_head       (w_head),
        .i_pop        (w_pop)
    );

    // emitter: serializes each job into result transfers
    irpwc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_kind       (o_m_tuser),
        .o_byte       (w_byte),
        .o_total      (w_total),
        .o_last       (o_m_tlast)
    );

    assign o_m_tdata = {6'd0, w_total, w_byte};

endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
// self-checking testbench for ir_pulse_width_capture: directed and random captures
// with an in-bench capture predictor and random stalls on both stream sides
// depends on irpwc_pkg and the ir_pulse_width_capture rtl
`timescale 1ns / 1ps
module tb_top;
    import irpwc_pkg::*;

    // sample channel commands and receiver levels (level is active low)
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_ARM   = 1'b1;
    localparam logic LVL_MARK  = 1'b0;
    localparam logic LVL_SPACE = 1'b1;

    // index with no register behind it, writes must be dropped
    localparam logic [2:0] CFG_UNUSED = 3'd7;

    localparam int HEADER_LEN  = 5;
    localparam int QUIET_LIMIT = 3000;   // cycles without any transfer before giving up
    localparam int MAX_REPORTS = 10;

    typedef enum logic [1:0] {
        CAP_OFF,
        CAP_MARK,
        CAP_SPACE,
        CAP_IDLE
    } t_cap_phase;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [9:0] total_length;
        logic       last;
    } t_capture_result;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata   = 8'd0;
    logic        i_s_tuser   = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [23:0] o_m_tdata;
    logic [1:0]  o_m_tuser;
    logic        o_m_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = 3'd0;
    logic [15:0] i_cfg_data  = 16'd0;

    ir_pulse_width_capture dut (.*);

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // capture predictor: own copy of registers and capture state
    // ---------------------------------------------------------------
    logic [7:0]  cfg_glitch      = RST_GLITCH;
    logic [15:0] cfg_end_gap     = RST_END_GAP;
    logic [15:0] cfg_idle_period = RST_IDLE_PERIOD;
    logic [7:0]  cfg_idle_limit  = RST_IDLE_LIMIT;
    logic [9:0]  cfg_len_limit   = RST_LEN_LIMIT;

    t_cap_phase  cap_phase = CAP_OFF;
    logic [15:0] tick_cnt  = 16'd0;
    logic [9:0]  widx      = 10'(HEADER_LEN);
    logic [7:0]  idle_cnt  = 8'd0;

    // results the block still owes, oldest first
    t_capture_result capture_results_q[$];

    int mismatches   = 0;
    int samples_sent = 0;
    bit sender_gaps  = 1'b0;
    bit ready_gaps   = 1'b0;

    function automatic void push_result(logic [1:0] kind, logic [7:0] b, logic [9:0] total);
        t_capture_result r;
        r.kind         = kind;
        r.data_byte    = b;
        r.total_length = total;
        r.last         = 1'b0;
        capture_results_q.push_back(r);
    endfunction

    // tick counter sticks at its maximum
    function automatic void count_tick();
        if (tick_cnt != 16'hFFFF)
            tick_cnt = tick_cnt + 16'd1;
    endfunction

    // write index sticks at INDEX_MAX
    function automatic void advance_index(int by);
        int sum;
        sum = int'(widx) + by;
        widx = (sum > int'(INDEX_MAX)) ? INDEX_MAX : 10'(sum);
    endfunction

    // low byte zero: high byte alone, else 0, 0, low, high
    function automatic void emit_duration(logic [15:0] d);
        if (d[7:0] != 8'd0) begin
            push_result(KIND_DATA, 8'd0, 10'd0);
            push_result(KIND_DATA, 8'd0, 10'd0);
            push_result(KIND_DATA, d[7:0], 10'd0);
            push_result(KIND_DATA, d[15:8], 10'd0);
            advance_index(4);
        end else begin
            push_result(KIND_DATA, d[15:8], 10'd0);
            advance_index(1);
        end
    endfunction

    // one accepted sample transfer: update state, queue what it must produce
    function automatic void capture_step(logic cmd, logic lvl);
        int first;
        first = capture_results_q.size();
        if (cmd == CMD_ARM) begin
            // arming ignores the level
            cap_phase = CAP_MARK;
            tick_cnt  = 16'd1;
            widx      = 10'(HEADER_LEN);
            idle_cnt  = 8'd0;
        end else begin
            case (cap_phase)
                CAP_MARK: begin
                    // length limit is checked before anything else in a mark
                    if (widx >= cfg_len_limit) begin
                        push_result(KIND_OVERFLOW, 8'd0, 10'd0);
                        cap_phase = CAP_OFF;
                    end else if (lvl == LVL_MARK) begin
                        count_tick();
                    end else if (tick_cnt > 16'(cfg_glitch)) begin
                        emit_duration(tick_cnt);
                        tick_cnt  = 16'd1;
                        cap_phase = CAP_SPACE;
                    end else begin
                        // glitch: drop the mark, count kept into idle wait
                        cap_phase = CAP_IDLE;
                    end
                end
                CAP_SPACE: begin
                    if (lvl == LVL_SPACE) begin
                        count_tick();
                        if (tick_cnt > cfg_end_gap) begin
                            // terminator byte, then completion with header included
                            push_result(KIND_DATA, 8'd0, 10'd0);
                            advance_index(1);
                            push_result(KIND_COMPLETE, 8'd0, widx);
                            cap_phase = CAP_OFF;
                        end
                    end else if (widx >= cfg_len_limit) begin
                        push_result(KIND_OVERFLOW, 8'd0, 10'd0);
                        cap_phase = CAP_OFF;
                    end else begin
                        emit_duration(tick_cnt);
                        idle_cnt  = 8'd0;
                        tick_cnt  = 16'd1;
                        cap_phase = CAP_MARK;
                    end
                end
                CAP_IDLE: begin
                    if (lvl == LVL_SPACE) begin
                        count_tick();
                        if (tick_cnt > cfg_idle_period) begin
                            tick_cnt = 16'd0;
                            if (int'(idle_cnt) + 1 > int'(cfg_idle_limit)) begin
                                push_result(KIND_TIMEOUT, 8'd0, 10'd0);
                                cap_phase = CAP_OFF;
                            end else begin
                                idle_cnt = idle_cnt + 8'd1;
                            end
                        end
                    end else begin
                        tick_cnt  = 16'd1;
                        cap_phase = CAP_MARK;
                    end
                end
                default: ;   // disarmed, ticks are ignored
            endcase
        end
        // tlast on the final result of this sample
        if (capture_results_q.size() > first)
            capture_results_q[capture_results_q.size() - 1].last = 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // run lengths clustered around a threshold so both sides of it are hit
    function automatic int run_len(int th);
        int lo;
        lo = (th > 1) ? th - 1 : 1;
        case ($urandom_range(0, 3))
            0:       return $urandom_range(1, 3);
            1, 2:    return $urandom_range(lo, th + 2);
            default: return $urandom_range(1, th + 4);
        endcase
    endfunction

    // one sample transfer; tvalid stays high when the next one follows at once
    task automatic send_sample(input logic cmd, input logic lvl);
        int gap;
        gap = 0;
        if (sender_gaps && $urandom_range(0, 3) == 0)
            gap = pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= {7'd0, lvl};
        do @(posedge i_clk); while (!o_s_tready);
        capture_step(cmd, lvl);
        samples_sent++;
    endtask

    task automatic send_run(input logic lvl, input int n);
        repeat (n) send_sample(CMD_TICK, lvl);
    endtask

    // stop sampling and wait until every owed result has come out, plus a margin
    // for samples still in flight that produce nothing
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (capture_results_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // valid is left high here, the caller lowers it after the last write
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_GLITCH:      cfg_glitch      = value[7:0];
            CFG_END_GAP:     cfg_end_gap     = value;
            CFG_IDLE_PERIOD: cfg_idle_period = value;
            CFG_IDLE_LIMIT:  cfg_idle_limit  = value[7:0];
            CFG_LEN_LIMIT:   cfg_len_limit   = value[9:0];
            default: ;
        endcase
    endtask

    // register writes only once the block has gone quiet
    task automatic configure(input int glitch, input int end_gap, input int idle_period,
                             input int idle_limit, input int len_limit, input bit poke_unused);
        drain_results();
        if (poke_unused)
            write_reg(CFG_UNUSED, 16'hFFFF);
        write_reg(CFG_GLITCH, 16'(glitch));
        write_reg(CFG_END_GAP, 16'(end_gap));
        write_reg(CFG_IDLE_PERIOD, 16'(idle_period));
        write_reg(CFG_IDLE_LIMIT, 16'(idle_limit));
        write_reg(CFG_LEN_LIMIT, 16'(len_limit));
        i_cfg_valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // register defaults straight out of reset, full rate
    task automatic test_reset_defaults();
        send_sample(CMD_TICK, LVL_MARK);        // disarmed ticks do nothing
        send_sample(CMD_TICK, LVL_SPACE);
        send_sample(CMD_ARM, LVL_SPACE);        // level ignored while arming
        send_run(LVL_MARK, 2);                  // mark of 3 ticks, a glitch
        send_sample(CMD_TICK, LVL_SPACE);
        send_run(LVL_SPACE, 3);                 // idle wait
        send_sample(CMD_TICK, LVL_MARK);        // back to mark
        send_run(LVL_MARK, 9);                  // mark of 10 ticks
        send_sample(CMD_TICK, LVL_SPACE);
        send_run(LVL_SPACE, 4);                 // space stays below the default end gap
    endtask

    // short sequences covering every result kind at tiny thresholds
    task automatic test_directed();
        // glitch off, smallest length limit: space overflow and completion
        configure(0, 1, 1, 0, 16, 1'b1);
        send_sample(CMD_ARM, LVL_MARK);
        send_sample(CMD_TICK, LVL_SPACE);       // one-tick mark kept
        send_sample(CMD_TICK, LVL_MARK);        // one-tick space
        send_sample(CMD_TICK, LVL_SPACE);       // index now past 16
        send_sample(CMD_TICK, LVL_MARK);        // overflow while ending a space
        send_sample(CMD_ARM, LVL_SPACE);
        send_sample(CMD_TICK, LVL_SPACE);
        send_sample(CMD_TICK, LVL_SPACE);       // space of 2 > 1: terminator, complete
        send_sample(CMD_TICK, LVL_MARK);
        send_sample(CMD_TICK, LVL_SPACE);

        // one-tick glitches, idle recovery, overflow at the start of a mark, timeout
        configure(1, 3, 1, 0, 20, 1'b0);
        send_sample(CMD_ARM, LVL_MARK);
        send_sample(CMD_TICK, LVL_SPACE);       // glitch, into idle wait
        send_sample(CMD_TICK, LVL_MARK);        // idle back to mark
        send_sample(CMD_TICK, LVL_MARK);
        send_sample(CMD_TICK, LVL_SPACE);       // mark of 2 kept
        send_sample(CMD_TICK, LVL_MARK);        // space of 1
        send_sample(CMD_TICK, LVL_MARK);
        send_sample(CMD_TICK, LVL_SPACE);
        send_sample(CMD_TICK, LVL_MARK);        // index 21 in mark
        send_sample(CMD_TICK, LVL_MARK);        // overflow in mark
        send_sample(CMD_ARM, LVL_MARK);
        send_sample(CMD_TICK, LVL_SPACE);       // glitch
        send_sample(CMD_TICK, LVL_SPACE);       // one idle period over a zero limit
    endtask

    // one armed capture: alternating runs around the thresholds, some noise
    task automatic random_capture();
        logic lvl;
        int   th;
        send_sample(CMD_ARM, 1'($urandom_range(0, 1)));
        lvl = LVL_MARK;
        repeat ($urandom_range(1, 8)) begin
            if (lvl == LVL_MARK)
                th = int'(cfg_glitch);
            else
                th = $urandom_range(0, 2) != 0 ? int'(cfg_end_gap) : int'(cfg_idle_period);
            send_run(lvl, run_len(th));
            if ($urandom_range(0, 11) == 0)
                send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            lvl = ~lvl;
        end
        if ($urandom_range(0, 1) != 0)
            send_run(LVL_SPACE, int'(cfg_end_gap) + 2);
        if ($urandom_range(0, 5) == 0)
            send_run(1'($urandom_range(0, 1)), $urandom_range(1, 3));
    endtask

    task automatic test_random_captures();
        int start;
        for (int round = 0; round < 3; round++) begin
            configure($urandom_range(0, 4), $urandom_range(1, 10), $urandom_range(1, 5),
                      $urandom_range(0, 3), $urandom_range(16, 48), 1'b0);
            sender_gaps = ($urandom_range(0, 3) != 0);
            ready_gaps  = ($urandom_range(0, 3) != 0);
            start = samples_sent;
            while (samples_sent - start < 30)
                random_capture();
        end
    endtask

    // ---------------------------------------------------------------
    // result side: random backpressure and checking
    // ---------------------------------------------------------------
    int stall_left = 0;

    always @(posedge i_clk) begin
        if (ready_gaps && stall_left == 0 && $urandom_range(0, 3) == 0)
            stall_left = pick_gap();
        if (stall_left > 0) begin
            i_m_tready <= 1'b0;
            stall_left--;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    function automatic void note_mismatch(string what, int want, int got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch at %0t ns: %s expected %0d got %0d", $time, what, want, got);
    endfunction

    // every result transfer is compared with the oldest owed result
    always @(posedge i_clk) begin : result_check
        t_capture_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (capture_results_q.size() == 0) begin
                note_mismatch("unexpected result, kind", -1, int'(o_m_tuser));
            end else begin
                want = capture_results_q.pop_front();
                if (o_m_tuser != want.kind)
                    note_mismatch("kind", int'(want.kind), int'(o_m_tuser));
                if (o_m_tdata[7:0] != want.data_byte)
                    note_mismatch("data_byte", int'(want.data_byte), int'(o_m_tdata[7:0]));
                if (o_m_tdata[17:8] != want.total_length)
                    note_mismatch("total_length", int'(want.total_length),
                                  int'(o_m_tdata[17:8]));
                if (o_m_tlast != want.last)
                    note_mismatch("tlast", int'(want.last), int'(o_m_tlast));
            end
        end
    end

    // watchdog: too long without any transfer on any channel means a hang
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[ir_pulse_width_capture] ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_directed();
        test_random_captures();

        drain_results();
        repeat (20) @(posedge i_clk);   // catch stray results after the last one

        if (mismatches == 0 && capture_results_q.size() == 0)
            $display("[ir_pulse_width_capture] OK");
        else
            $display("[ir_pulse_width_capture] ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/irpwc_pkg.sv
sv/irpwc_front.sv
sv/irpwc_queue.sv
sv/irpwc_back.sv
sv/ir_pulse_width_capture.sv
test/tb_top.sv
